// ===== rtl/mbw_pkg.sv =====
// shared types, constants and helper functions of the maze backtracker walk
package mbw_pkg;

   // fixed field widths
   localparam int CFG_W       = 7;
   localparam int COORD_W     = 6;
   localparam int RAND_W      = 15;
   localparam int CSR_INDEX_W = 4;

   // parameter defaults
   localparam int MAX_WIDTH_DEF   = 64;
   localparam int MAX_HEIGHT_DEF  = 64;
   localparam int STACK_DEPTH_DEF = 1024;

   // size register reset value
   localparam int MAZE_SIZE_RESET = 15;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_MAZE_WIDTH  = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_MAZE_HEIGHT = CSR_INDEX_W'(1);

   typedef logic [COORD_W-1:0] coord_type;

   typedef enum logic [1:0] {
      ST_CARVED    = 2'd0,
      ST_BACKTRACK = 2'd1,
      ST_FINISHED  = 2'd2,
      ST_RESTARTED = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      DIR_UP    = 2'd0,
      DIR_LEFT  = 2'd1,
      DIR_DOWN  = 2'd2,
      DIR_RIGHT = 2'd3
   } dir_type;

   typedef struct packed {
      logic              restart;
      logic [RAND_W-1:0] rand_value;
   } req_type;

   typedef struct packed {
      status_type status;
      coord_type  wall_x;
      coord_type  wall_y;
      coord_type  cell_x;
      coord_type  cell_y;
   } rsp_type;

   typedef enum logic [3:0] {
      S_INIT,
      S_IDLE,
      S_WIPE,
      S_SEED,
      S_PROBE,
      S_LAST,
      S_DECIDE,
      S_CARVE,
      S_POP,
      S_RESP
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic clear_step;
      logic seed;
      logic probe;
      logic decide;
      logic carve;
      logic pop_load;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic req_restart;
      logic stack_empty;
      logic clear_last;
      logic probe_last;
      logic none_avail;
   } dp_status_type;

   // value mod 3: base-4 digits sum, since 4 is 1 mod 3
   function automatic logic [1:0] mod3(input logic [RAND_W-1:0] v);
      logic [15:0] p;
      logic [4:0]  s;
      logic [3:0]  t;
      logic [2:0]  u;
      p = 16'(v);
      s = '0;
      for (int i = 0; i < 8; i++) begin
         s = s + 5'(p[2*i +: 2]);
      end
      t = 4'(s[4:2]) + 4'(s[1:0]);
      u = 3'(t[3:2]) + 3'(t[1:0]);
      if (u >= 3'd3) begin
         u = u - 3'd3;
      end
      return u[1:0];
   endfunction

   // direction of the idx-th open candidate
   function automatic dir_type pick_dir(input logic [3:0] avail, input logic [1:0] idx);
      dir_type    d;
      logic [1:0] seen;
      d    = DIR_UP;
      seen = '0;
      for (int i = 0; i < 4; i++) begin
         if (avail[i]) begin
            if (seen == idx) begin
               d = dir_type'(2'(i));
            end
            seen = seen + 2'd1;
         end
      end
      return d;
   endfunction

endpackage

// ===== rtl/mbw_ram.sv =====
// generic simple dual-port ram with registered read
module mbw_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/mbw_ctrl.sv =====
// step sequencer of the maze backtracker walk
module mbw_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  mbw_pkg::dp_status_type sts,
   output mbw_pkg::ctrl_cmd_type  cmd,
   output logic                  busy,
   output logic                  rsp_strobe
);
   import mbw_pkg::*;

   state_type state_ff;
   state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_INIT: begin
            if (sts.clear_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               if (sts.req_restart)      state_in = S_WIPE;
               else if (sts.stack_empty) state_in = S_RESP;
               else                      state_in = S_PROBE;
            end
         end
         S_WIPE: begin
            if (sts.clear_last) state_in = S_SEED;
         end
         S_SEED:  state_in = S_RESP;
         S_PROBE: begin
            if (sts.probe_last) state_in = S_LAST;
         end
         S_LAST:   state_in = S_DECIDE;
         S_DECIDE: state_in = sts.none_avail ? S_POP : S_CARVE;
         S_CARVE:  state_in = S_RESP;
         S_POP:    state_in = S_RESP;
         S_RESP:   state_in = S_IDLE;
         default:  state_in = S_INIT;
      endcase
   end

   // outputs
   always_comb begin
      cmd        = '0;
      busy       = 1'b1;
      rsp_strobe = 1'b0;
      unique case (state_ff)
         S_INIT:   cmd.clear_step = 1'b1;
         S_IDLE: begin
            busy       = 1'b0;
            cmd.accept = start;
         end
         S_WIPE:   cmd.clear_step = 1'b1;
         S_SEED:   cmd.seed = 1'b1;
         S_PROBE:  cmd.probe = 1'b1;
         S_LAST:   ;
         S_DECIDE: cmd.decide = 1'b1;
         S_CARVE:  cmd.carve = 1'b1;
         S_POP:    cmd.pop_load = 1'b1;
         S_RESP:   rsp_strobe = 1'b1;
         default:  ;
      endcase
   end

endmodule

// ===== rtl/mbw_datapath.sv =====
// grid and stack memories, neighbour probing, choice and result register
module mbw_datapath #(
   parameter int MAX_WIDTH   = mbw_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT  = mbw_pkg::MAX_HEIGHT_DEF,
   parameter int STACK_DEPTH = mbw_pkg::STACK_DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  mbw_pkg::ctrl_cmd_type           cmd,
   output mbw_pkg::dp_status_type          sts,
   input  mbw_pkg::req_type                req_data,
   input  logic                            csr_write,
   input  logic [mbw_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [mbw_pkg::CFG_W-1:0]       csr_data,
   output mbw_pkg::rsp_type                rsp_data
);
   import mbw_pkg::*;

   localparam int XW   = $clog2(MAX_WIDTH);
   localparam int YW   = $clog2(MAX_HEIGHT);
   localparam int GAW  = XW + YW;
   localparam int GDEP = 2 ** GAW;
   localparam int SAW  = $clog2(STACK_DEPTH);
   localparam int CW   = $clog2(STACK_DEPTH + 1);
   localparam int SZX  = (XW + 2 > CFG_W) ? XW + 2 : CFG_W;
   localparam int SZY  = (YW + 2 > CFG_W) ? YW + 2 : CFG_W;

   // control registers
   logic [CFG_W-1:0] width_ff, width_in;
   logic [CFG_W-1:0] height_ff, height_in;
   logic [GAW-1:0]   clr_addr_ff, clr_addr_in;
   dir_type          probe_dir_ff, probe_dir_in;
   logic             cap_valid_ff, cap_valid_in;
   logic [CW-1:0]    count_ff, count_in;

   // payload registers
   dir_type          cap_dir_ff, cap_dir_in;
   logic [3:0]       avail_ff, avail_in;
   logic [1:0]       rnd_lo_ff, rnd_lo_in;
   logic [1:0]       rnd_mod3_ff, rnd_mod3_in;
   logic [XW-1:0]    top_x_ff, top_x_in, new_x_ff, new_x_in;
   logic [YW-1:0]    top_y_ff, top_y_in, new_y_ff, new_y_in;
   rsp_type          rsp_ff, rsp_in;

   // memory ports
   logic             grid_we, grid_wd, grid_rd;
   logic [GAW-1:0]   grid_wa, grid_ra;
   logic             st_we;
   logic [SAW-1:0]   st_wa, st_ra;
   logic [GAW-1:0]   st_wd, st_rd;

   // decision logic
   logic [SZX-1:0]   w_eff;
   logic [SZY-1:0]   h_eff;
   logic [3:0]       inb;
   logic [XW-1:0]    nb_x, cand_x, wall_x;
   logic [YW-1:0]    nb_y, cand_y, wall_y;
   logic [2:0]       n_avail;
   logic [1:0]       pick_idx;
   dir_type          pick;
   logic             room;

   mbw_ram #(.WIDTH(1), .DEPTH(GDEP)) u_grid (
      .clock   (clock),
      .wr_en   (grid_we),
      .wr_addr (grid_wa),
      .wr_data (grid_wd),
      .rd_addr (grid_ra),
      .rd_data (grid_rd)
   );

   mbw_ram #(.WIDTH(GAW), .DEPTH(STACK_DEPTH)) u_stack (
      .clock   (clock),
      .wr_en   (st_we),
      .wr_addr (st_wa),
      .wr_data (st_wd),
      .rd_addr (st_ra),
      .rd_data (st_rd)
   );

   // effective sizes clipped to the grid
   assign w_eff = (SZX'(width_ff) < SZX'(MAX_WIDTH)) ? SZX'(width_ff) : SZX'(MAX_WIDTH);
   assign h_eff = (SZY'(height_ff) < SZY'(MAX_HEIGHT)) ? SZY'(height_ff) : SZY'(MAX_HEIGHT);

   // neighbour bounds of the top cell
   always_comb begin
      inb[DIR_UP]    = top_y_ff >= YW'(2);
      inb[DIR_LEFT]  = top_x_ff >= XW'(2);
      inb[DIR_DOWN]  = (SZY'(top_y_ff) + SZY'(2)) < h_eff;
      inb[DIR_RIGHT] = (SZX'(top_x_ff) + SZX'(2)) < w_eff;
   end

   // neighbour address for the probe
   always_comb begin
      nb_x = top_x_ff;
      nb_y = top_y_ff;
      unique case (probe_dir_ff)
         DIR_UP:    nb_y = top_y_ff - YW'(2);
         DIR_LEFT:  nb_x = top_x_ff - XW'(2);
         DIR_DOWN:  nb_y = top_y_ff + YW'(2);
         DIR_RIGHT: nb_x = top_x_ff + XW'(2);
         default:   ;
      endcase
   end

   // candidate choice from the random value
   always_comb begin
      n_avail = 3'($countones(avail_ff));
      case (n_avail)
         3'd2:    pick_idx = {1'b0, rnd_lo_ff[0]};
         3'd3:    pick_idx = rnd_mod3_ff;
         3'd4:    pick_idx = rnd_lo_ff;
         default: pick_idx = 2'd0;
      endcase
      pick = pick_dir(avail_ff, pick_idx);
   end

   // wall and new cell of the chosen direction
   always_comb begin
      wall_x = top_x_ff;
      wall_y = top_y_ff;
      cand_x = top_x_ff;
      cand_y = top_y_ff;
      unique case (pick)
         DIR_UP: begin
            wall_y = top_y_ff - YW'(1);
            cand_y = top_y_ff - YW'(2);
         end
         DIR_LEFT: begin
            wall_x = top_x_ff - XW'(1);
            cand_x = top_x_ff - XW'(2);
         end
         DIR_DOWN: begin
            wall_y = top_y_ff + YW'(1);
            cand_y = top_y_ff + YW'(2);
         end
         DIR_RIGHT: begin
            wall_x = top_x_ff + XW'(1);
            cand_x = top_x_ff + XW'(2);
         end
         default: ;
      endcase
   end

   assign room = count_ff < CW'(STACK_DEPTH);

   // grid memory ports
   always_comb begin
      grid_we = cmd.clear_step | cmd.seed | (cmd.decide & (|avail_ff)) | cmd.carve;
      grid_wd = cmd.clear_step;
      if (cmd.clear_step)  grid_wa = clr_addr_ff;
      else if (cmd.seed)   grid_wa = {XW'(1), YW'(1)};
      else if (cmd.decide) grid_wa = {wall_x, wall_y};
      else                 grid_wa = {new_x_ff, new_y_ff};
      grid_ra = {nb_x, nb_y};
   end

   // stack memory ports
   always_comb begin
      st_we = cmd.seed | (cmd.carve & room);
      st_wa = cmd.seed ? '0 : SAW'(count_ff);
      st_wd = cmd.seed ? {XW'(1), YW'(1)} : {new_x_ff, new_y_ff};
      st_ra = SAW'(count_ff - CW'(2));
   end

   // next values
   always_comb begin
      width_in     = width_ff;
      height_in    = height_ff;
      clr_addr_in  = clr_addr_ff;
      probe_dir_in = probe_dir_ff;
      cap_valid_in = cmd.probe;
      cap_dir_in   = probe_dir_ff;
      count_in     = count_ff;
      avail_in     = avail_ff;
      rnd_lo_in    = rnd_lo_ff;
      rnd_mod3_in  = rnd_mod3_ff;
      top_x_in     = top_x_ff;
      top_y_in     = top_y_ff;
      new_x_in     = new_x_ff;
      new_y_in     = new_y_ff;
      rsp_in       = rsp_ff;

      // size registers
      if (csr_write) begin
         case (csr_index)
            CSR_MAZE_WIDTH:  width_in = csr_data;
            CSR_MAZE_HEIGHT: height_in = csr_data;
            default:         ;
         endcase
      end

      // request capture
      if (cmd.accept) begin
         rnd_lo_in    = req_data.rand_value[1:0];
         rnd_mod3_in  = mod3(req_data.rand_value);
         probe_dir_in = DIR_UP;
         if (!req_data.restart && count_ff == '0) begin
            rsp_in = '{ST_FINISHED, '0, '0, '0, '0};
         end
      end

      // grid wipe sweep
      if (cmd.clear_step) begin
         clr_addr_in = clr_addr_ff + GAW'(1);
      end

      // new walk from the start cell
      if (cmd.seed) begin
         top_x_in = XW'(1);
         top_y_in = YW'(1);
         count_in = CW'(1);
         rsp_in   = '{ST_RESTARTED, '0, '0, coord_type'(1), coord_type'(1)};
      end

      // neighbour probe, data lands in the next cycle
      if (cmd.probe) begin
         probe_dir_in = dir_type'(probe_dir_ff + 2'd1);
      end
      if (cap_valid_ff) begin
         avail_in[cap_dir_ff] = inb[cap_dir_ff] & grid_rd;
      end

      // pop or open the wall
      if (cmd.decide) begin
         if (avail_ff == '0) begin
            count_in = count_ff - CW'(1);
            rsp_in   = '{ST_BACKTRACK, '0, '0, '0, '0};
         end else begin
            new_x_in = cand_x;
            new_y_in = cand_y;
            rsp_in   = '{ST_CARVED, coord_type'(wall_x), coord_type'(wall_y),
                         coord_type'(cand_x), coord_type'(cand_y)};
         end
      end

      // reload top after a pop
      if (cmd.pop_load && count_ff != '0) begin
         top_x_in      = st_rd[GAW-1:YW];
         top_y_in      = st_rd[YW-1:0];
         rsp_in.cell_x = coord_type'(st_rd[GAW-1:YW]);
         rsp_in.cell_y = coord_type'(st_rd[YW-1:0]);
      end

      // push the new cell if there is room
      if (cmd.carve && room) begin
         top_x_in = new_x_ff;
         top_y_in = new_y_ff;
         count_in = count_ff + CW'(1);
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= CFG_W'(MAZE_SIZE_RESET);
         height_ff    <= CFG_W'(MAZE_SIZE_RESET);
         clr_addr_ff  <= '0;
         probe_dir_ff <= DIR_UP;
         cap_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         clr_addr_ff  <= clr_addr_in;
         probe_dir_ff <= probe_dir_in;
         cap_valid_ff <= cap_valid_in;
         count_ff     <= count_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cap_dir_ff  <= cap_dir_in;
      avail_ff    <= avail_in;
      rnd_lo_ff   <= rnd_lo_in;
      rnd_mod3_ff <= rnd_mod3_in;
      top_x_ff    <= top_x_in;
      top_y_ff    <= top_y_in;
      new_x_ff    <= new_x_in;
      new_y_ff    <= new_y_in;
      rsp_ff      <= rsp_in;
   end

   // status to the controller
   always_comb begin
      sts.req_restart = req_data.restart;
      sts.stack_empty = count_ff == '0;
      sts.clear_last  = &clr_addr_ff;
      sts.probe_last  = probe_dir_ff == DIR_RIGHT;
      sts.none_avail  = avail_ff == '0;
   end

   assign rsp_data = rsp_ff;

endmodule

// ===== rtl/maze_backtracker_walk.sv =====
// maze backtracker walk: one depth-first carving step per request
// walk step: four grid probes through the one grid read port, choice, then wall and cell
//   writes or a stack read, then the strobe; busy stays high, so a new request waits for the result
// empty stack: strobe in the cycle after the request; restart: a wipe of the whole grid memory,
//   then the seed write of the start cell and the strobe; reset runs the same wipe with busy high
// synchronous reset: sizes 15x15, stack empty; results cannot be stalled
module maze_backtracker_walk #(
   parameter int MAX_WIDTH   = mbw_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT  = mbw_pkg::MAX_HEIGHT_DEF,
   parameter int STACK_DEPTH = mbw_pkg::STACK_DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  mbw_pkg::req_type                req_data,
   output logic                            rsp_strobe,
   output mbw_pkg::rsp_type                rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [mbw_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [mbw_pkg::CFG_W-1:0]       csr_data
);
   import mbw_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type sts;

   // size registers always take writes
   assign csr_ready = 1'b1;

   mbw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .sts        (sts),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   mbw_datapath #(
      .MAX_WIDTH   (MAX_WIDTH),
      .MAX_HEIGHT  (MAX_HEIGHT),
      .STACK_DEPTH (STACK_DEPTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_data  (req_data),
      .csr_write (csr_valid & csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_data  (rsp_data)
   );

   // a result strobe is a single cycle
   assert property (@(posedge clock) disable iff (reset) rsp_strobe |=> !rsp_strobe)
      else $error("result strobe longer than one cycle");

   // a taken request keeps the block busy
   assert property (@(posedge clock) disable iff (reset) (start && !busy) |=> busy)
      else $error("block not busy after a request");

   // finished walk reports no coordinates
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.status == ST_FINISHED) |->
         (rsp_data.cell_x == '0 && rsp_data.cell_y == '0 &&
          rsp_data.wall_x == '0 && rsp_data.wall_y == '0))
      else $error("finished result with coordinates");

   // the walk step runs only after the probes
   assert property (@(posedge clock) disable iff (reset) cmd.decide |-> $past(!cmd.probe))
      else $error("decision taken straight after a probe");

endmodule

// ===== dv/mbw_walk_checker.sv =====
// checker for the maze backtracker walk: mirrors the carving walk and compares each result
module mbw_walk_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic                            busy,
   input  mbw_pkg::req_type                req_data,
   input  logic                            rsp_strobe,
   input  mbw_pkg::rsp_type                rsp_data,
   input  logic                            csr_valid,
   input  logic                            csr_ready,
   input  logic [mbw_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [mbw_pkg::CFG_W-1:0]       csr_data,
   input  logic                            run_done,
   output int                              fail_count,
   output int                              pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import mbw_pkg::*;

   localparam int GRID_COLS  = MAX_WIDTH_DEF;
   localparam int GRID_ROWS  = MAX_HEIGHT_DEF;
   localparam int TRAIL_SIZE = STACK_DEPTH_DEF;

   // mirrored walk state: wall bits, path of visited cells, size registers
   logic               wall_bits [0:GRID_COLS*GRID_ROWS-1];
   logic [COORD_W-1:0] trail_x [0:TRAIL_SIZE-1];
   logic [COORD_W-1:0] trail_y [0:TRAIL_SIZE-1];
   int                 trail_len;
   logic [CFG_W-1:0]   cols_reg;
   logic [CFG_W-1:0]   rows_reg;

   rsp_type            step_q[$];
   int                 faults = 0;
   bit                 leftover_seen = 1'b0;

   function automatic int grid_addr(input int x, input int y);
      return x * GRID_ROWS + y;
   endfunction

   task automatic report_fault(input string msg);
      faults++;
      $display("[%0t] mismatch: %s", $time, msg);
   endtask

   task automatic check_field(input string name, input logic [COORD_W-1:0] got,
                              input logic [COORD_W-1:0] want);
      if (got !== want) begin
         report_fault($sformatf("%s got %0d expected %0d", name, got, want));
      end
   endtask

   // one walk step on the mirrored state
   task automatic carve_step(input req_type rq, output rsp_type rs);
      int      w;
      int      h;
      int      x;
      int      y;
      int      n;
      int      wx;
      int      wy;
      dir_type cand [4];
      dir_type pick;
      w  = (int'(cols_reg) < GRID_COLS) ? int'(cols_reg) : GRID_COLS;
      h  = (int'(rows_reg) < GRID_ROWS) ? int'(rows_reg) : GRID_ROWS;
      rs = '0;
      if (rq.restart) begin
         // fresh grid, walk seeded at the corner cell
         for (int i = 0; i < GRID_COLS*GRID_ROWS; i++) begin
            wall_bits[i] = 1'b1;
         end
         wall_bits[grid_addr(1, 1)] = 1'b0;
         trail_x[0]  = COORD_W'(1);
         trail_y[0]  = COORD_W'(1);
         trail_len   = 1;
         rs.status   = ST_RESTARTED;
         rs.cell_x   = COORD_W'(1);
         rs.cell_y   = COORD_W'(1);
      end else if (trail_len == 0) begin
         rs.status = ST_FINISHED;
      end else begin
         x = trail_x[trail_len-1];
         y = trail_y[trail_len-1];
         n = 0;
         // unvisited cells two away, up, left, down, right
         if (y >= 2 && wall_bits[grid_addr(x, y-2)]) begin
            cand[n] = DIR_UP;
            n++;
         end
         if (x >= 2 && wall_bits[grid_addr(x-2, y)]) begin
            cand[n] = DIR_LEFT;
            n++;
         end
         if (y + 2 < h && wall_bits[grid_addr(x, y+2)]) begin
            cand[n] = DIR_DOWN;
            n++;
         end
         if (x + 2 < w && wall_bits[grid_addr(x+2, y)]) begin
            cand[n] = DIR_RIGHT;
            n++;
         end
         if (n == 0) begin
            // dead end, step back along the path
            trail_len--;
            rs.status = ST_BACKTRACK;
            if (trail_len != 0) begin
               rs.cell_x = trail_x[trail_len-1];
               rs.cell_y = trail_y[trail_len-1];
            end
         end else begin
            pick = cand[int'(rq.rand_value) % n];
            wx   = x;
            wy   = y;
            case (pick)
               DIR_UP: begin
                  wy = y - 1;
                  y  = y - 2;
               end
               DIR_LEFT: begin
                  wx = x - 1;
                  x  = x - 2;
               end
               DIR_DOWN: begin
                  wy = y + 1;
                  y  = y + 2;
               end
               default: begin
                  wx = x + 1;
                  x  = x + 2;
               end
            endcase
            wall_bits[grid_addr(wx, wy)] = 1'b0;
            wall_bits[grid_addr(x, y)]   = 1'b0;
            // a full path keeps the old top cell
            if (trail_len < TRAIL_SIZE) begin
               trail_x[trail_len] = COORD_W'(x);
               trail_y[trail_len] = COORD_W'(y);
               trail_len++;
            end
            rs.status = ST_CARVED;
            rs.wall_x = COORD_W'(wx);
            rs.wall_y = COORD_W'(wy);
            rs.cell_x = COORD_W'(x);
            rs.cell_y = COORD_W'(y);
         end
      end
   endtask

   // watch the three channels at each rising edge
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < GRID_COLS*GRID_ROWS; i++) begin
            wall_bits[i] = 1'b1;
         end
         trail_len = 0;
         cols_reg  = CFG_W'(MAZE_SIZE_RESET);
         rows_reg  = CFG_W'(MAZE_SIZE_RESET);
         step_q.delete();
      end else begin
         // result against the oldest expectation
         if (rsp_strobe) begin
            if (step_q.size() == 0) begin
               report_fault("result with no request waiting");
            end else begin
               want = step_q.pop_front();
               check_field("status", COORD_W'(rsp_data.status), COORD_W'(want.status));
               check_field("wall_x", rsp_data.wall_x, want.wall_x);
               check_field("wall_y", rsp_data.wall_y, want.wall_y);
               check_field("cell_x", rsp_data.cell_x, want.cell_x);
               check_field("cell_y", rsp_data.cell_y, want.cell_y);
            end
         end
         // accepted request
         if (start && !busy) begin
            carve_step(req_data, want);
            step_q = {step_q, want};
         end
         // register write
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_MAZE_WIDTH:  cols_reg = csr_data;
               CSR_MAZE_HEIGHT: rows_reg = csr_data;
               default: ;
            endcase
         end
         // anything still owed once the run is over
         if (run_done && !leftover_seen && step_q.size() != 0) begin
            leftover_seen = 1'b1;
            report_fault($sformatf("%0d results never came", step_q.size()));
         end
      end
      fail_count <= faults;
      pending    <= step_q.size();
   end

endmodule

// ===== dv/maze_backtracker_walk_tb.sv =====
// testbench top for the maze backtracker walk: stimulus, timeout and verdict
module maze_backtracker_walk_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import mbw_pkg::*;

   localparam int CYCLE_LIMIT = 1_500_000;
   localparam int ITEM_TOTAL  = 1550;
   localparam int STEP_CAP    = 200;
   // an index with no register behind it
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = '1;

   logic                   clock;
   logic                   reset     = 1'b1;
   logic                   start     = 1'b0;
   req_type                req_data  = '0;
   logic                   csr_valid = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0]       csr_data  = '0;
   logic                   run_done  = 1'b0;
   logic                   busy;
   logic                   rsp_strobe;
   rsp_type                rsp_data;
   logic                   csr_ready;
   int                     fail_count;
   int                     pending;
   int                     cycles    = 0;
   int                     idle_pct  = 0;
   int                     sent      = 0;

   maze_backtracker_walk u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   mbw_walk_checker u_chk (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .run_done   (run_done),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // run length guard
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("maze_backtracker_walk test failed");
         $finish;
      end
   end

   // one request, after an optional random gap, held until taken
   task automatic send_step(input logic rs, input logic [RAND_W-1:0] rv);
      int gap;
      gap = ($urandom_range(99) < idle_pct) ? $urandom_range(12, 1) : 0;
      if (gap > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      @(negedge clock);
      start    <= 1'b1;
      req_data <= '{restart: rs, rand_value: rv};
      do @(posedge clock); while (busy);
      sent++;
   endtask

   // stop sending and wait until every result is back
   task automatic wait_drained();
      @(negedge clock);
      start <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [CFG_W-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_size(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
      wait_drained();
      write_reg(CSR_MAZE_WIDTH, w);
      write_reg(CSR_MAZE_HEIGHT, h);
   endtask

   initial begin
      int idle_phase [4];
      int walk;
      int w;
      int h;
      int cells;
      int steps;
      int r;
      idle_phase = '{0, 67, 37, 67};
      walk       = 0;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty walk after reset, restarts, extreme random values
      send_step(1'b0, '0);
      send_step(1'b1, '1);
      send_step(1'b0, '0);
      send_step(1'b0, '1);
      send_step(1'b0, 15'd1);
      send_step(1'b0, 15'd2);
      send_step(1'b0, 15'd3);
      send_step(1'b0, 15'h5555);
      // restart in the middle of a walk
      send_step(1'b1, 15'h2AAA);
      send_step(1'b0, 15'h2AAA);
      send_step(1'b0, 15'h4000);
      // smallest maze: one cell, pops straight to empty
      set_size(7'd3, 7'd3);
      send_step(1'b1, '0);
      send_step(1'b0, '1);
      send_step(1'b0, '0);
      // oversized registers clamp to the grid
      set_size('1, '1);
      send_step(1'b1, '1);
      send_step(1'b0, '1);
      send_step(1'b0, '1);
      send_step(1'b0, '0);
      // undersized registers
      set_size('0, '0);
      send_step(1'b1, '0);
      send_step(1'b0, '1);
      // size change during a walk, and a write to an unused index
      set_size(7'd5, 7'd7);
      send_step(1'b1, '0);
      send_step(1'b0, 15'd7);
      send_step(1'b0, 15'd9);
      wait_drained();
      write_reg(CSR_MAZE_WIDTH, 7'd2);
      send_step(1'b0, '1);
      wait_drained();
      write_reg(CSR_SPARE, '1);
      send_step(1'b0, '0);

      // random walks: mostly small mazes walked to the end, some noise restarts
      while (sent < ITEM_TOTAL) begin
         idle_pct = idle_phase[walk % 4];
         walk++;
         r = $urandom_range(99);
         if (r < 70) begin
            w = 3 + 2 * $urandom_range(6);
            h = 3 + 2 * $urandom_range(6);
         end else if (r < 85) begin
            w = $urandom_range(127);
            h = $urandom_range(127);
         end else if (r < 95) begin
            w = 17 + 2 * $urandom_range(7);
            h = 17 + 2 * $urandom_range(7);
         end else begin
            w = ($urandom_range(1) == 0) ? 64 : 127;
            h = ($urandom_range(1) == 0) ? 63 : 127;
         end
         if (walk % 6 != 5) begin
            set_size(CFG_W'(w), CFG_W'(h));
         end
         w     = (w < 64) ? w : 64;
         h     = (h < 64) ? h : 64;
         cells = (w >= 3 && h >= 3) ? ((w - 1) / 2) * ((h - 1) / 2) : 0;
         steps = 2 * cells + 3;
         steps = (steps < STEP_CAP) ? steps : STEP_CAP;
         send_step(1'b1, RAND_W'($urandom_range(32767)));
         for (int i = 0; i < steps && sent < ITEM_TOTAL; i++) begin
            if ($urandom_range(49) == 0) begin
               send_step(1'b1, RAND_W'($urandom_range(32767)));
            end else begin
               send_step(1'b0, RAND_W'($urandom_range(32767)));
            end
         end
      end

      // drain, settle, then flag anything still owed
      wait_drained();
      repeat (20) @(posedge clock);
      @(negedge clock);
      run_done <= 1'b1;
      repeat (3) @(posedge clock);
      if (fail_count == 0) begin
         $display("maze_backtracker_walk test passed");
      end else begin
         $display("maze_backtracker_walk test failed");
      end
      $finish;
   end

endmodule

// ===== maze_backtracker_walk.f =====
rtl/mbw_pkg.sv
rtl/mbw_ram.sv
rtl/mbw_ctrl.sv
rtl/mbw_datapath.sv
rtl/maze_backtracker_walk.sv
dv/mbw_walk_checker.sv
dv/maze_backtracker_walk_tb.sv
